/* hdl/dwm_pkg.sv */
package dwm_pkg;

	// default sample width, signed Q1.(w-1)
	localparam int SAMPLE_WIDTH_DEF = 16;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int REG_W  = 16;

	// internal formats
	localparam int X_W    = 32;  // sample in Q31
	localparam int MT_W   = 48;  // |x| * tone
	localparam int G1X_W  = 20;  // gain_one * 10
	localparam int G2X_W  = 24;  // gain_two * 250
	localparam int TERM_W = 36;  // sine term in Q31
	localparam int DRV_W  = 40;  // tanh argument in Q31
	localparam int BR_W   = 32;  // branch value in Q31

	typedef logic signed [X_W-1:0]    q31_t;
	typedef logic signed [DRV_W-1:0]  drv_t;
	typedef logic signed [TERM_W-1:0] term_t;

	// 300 / (2 pi) in Q16, turns per unit of x
	localparam logic [21:0] K_TURNS     = 22'd3129114;
	localparam logic [24:0] INV_LN2_Q24 = 25'd24204406;
	localparam logic [29:0] LN2_Q30     = 30'd744261118;
	localparam logic [30:0] ONE30       = 31'h4000_0000;

	// quarter wave sine, odd polynomial in Q30, lowest order first
	localparam logic signed [31:0] SIN_COEF [5] = '{
		32'sd1686629713, -32'sd693598668, 32'sd85569305, -32'sd5026995, 32'sd172272
	};

	// exp(-r) taylor series in Q30, lowest order first
	localparam logic signed [31:0] EXP_COEF [9] = '{
		32'sd1073741824, 32'sd1073741824, 32'sd536870912, 32'sd178956971,
		32'sd44739243, 32'sd8947849, 32'sd1491308, 32'sd213044, 32'sd26631
	};

	// q30 product with floor shift
	function automatic logic signed [33:0] mul30(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p[63:30];
	endfunction

endpackage

/* hdl/dwm_sine.sv */
module dwm_sine import dwm_pkg::*; (
	input  logic              clk,
	input  logic [8:0]        adv,
	input  logic [MT_W-1:0]   mt,
	input  logic              neg,
	input  logic [G1X_W-1:0]  g1x,
	output term_t             term
);

	logic [61:0]        phase_prod;
	logic [31:0]        phase_s2;
	logic [30:0]        h_raw;
	logic [30:0]        h_fold;
	logic [61:0]        h_sq;
	logic               neg_s [2:9];
	logic [30:0]        h_s [3:8];
	logic [30:0]        z2_s [4:7];
	logic signed [31:0] acc_s [5:8];
	logic signed [31:0] acc_in [5:8];
	logic signed [33:0] s_prod;
	logic [30:0]        s_clamp;
	logic [30:0]        s_s9;
	logic signed [31:0] s_signed;
	logic signed [51:0] t_prod;

	// phase as a 32-bit turn count
	assign phase_prod = 62'(mt[MT_W-1:8]) * 62'(K_TURNS);

	// fold the half wave to a quarter wave
	assign h_raw  = phase_s2[30:0];
	assign h_fold = (h_raw > ONE30) ? (31'd0 - h_raw) : h_raw;
	assign h_sq   = 62'(h_s[3]) * 62'(h_s[3]);

	// horner operand feed
	always_comb begin
		acc_in[5] = SIN_COEF[4];
		for (int j = 6; j <= 8; j++)
			acc_in[j] = acc_s[j-1];
	end

	// last horner step, clamp to [0, 1]
	assign s_prod  = mul30(acc_s[8], $signed({1'b0, h_s[8]}));
	assign s_clamp = (s_prod < 0) ? 31'd0 :
		(s_prod > $signed(34'(ONE30))) ? ONE30 : s_prod[30:0];

	// signed sine times depth
	assign s_signed = neg_s[9] ? -$signed({1'b0, s_s9}) : $signed({1'b0, s_s9});
	assign t_prod   = 52'(s_signed) * 52'($signed({1'b0, g1x}));

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			phase_s2  <= phase_prod[54:23];
			neg_s[2]  <= neg;
		end
		if (adv[1]) begin
			h_s[3]    <= h_fold;
			neg_s[3]  <= neg_s[2] ^ phase_s2[31];
		end
		if (adv[2]) begin
			z2_s[4]   <= h_sq[60:30];
			h_s[4]    <= h_s[3];
			neg_s[4]  <= neg_s[3];
		end
		for (int j = 5; j <= 8; j++) begin
			if (adv[j-2]) begin
				acc_s[j] <= 32'(mul30(acc_in[j], $signed({1'b0, z2_s[j-1]})))
					+ SIN_COEF[8-j];
				h_s[j]   <= h_s[j-1];
				neg_s[j] <= neg_s[j-1];
				if (j <= 7)
					z2_s[j] <= z2_s[j-1];
			end
		end
		if (adv[7]) begin
			s_s9     <= s_clamp;
			neg_s[9] <= neg_s[8];
		end
		if (adv[8])
			term <= t_prod[50:15];
	end

endmodule

/* hdl/dwm_div.sv */
module dwm_div import dwm_pkg::*; (
	input  logic        clk,
	input  logic [7:0]  adv,
	input  logic [30:0] num,
	input  logic [31:0] den,
	output logic [31:0] quo
);

	localparam int DIV_STAGES = 8;
	localparam int STEPS      = 4;

	logic [31:0] rem_s [DIV_STAGES-1];
	logic [31:0] den_s [DIV_STAGES-1];
	logic [31:0] q_s   [DIV_STAGES];

	// one restoring step, optional shift of the partial remainder
	function automatic logic [32:0] div_step(input logic [31:0] rem,
			input logic [31:0] d, input logic shift);
		logic [32:0] w;
		w = shift ? {rem, 1'b0} : {1'b0, rem};
		if (w >= {1'b0, d})
			return {1'b1, 32'(w - {1'b0, d})};
		return {1'b0, w[31:0]};
	endfunction

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic [31:0] rem_in;
		logic [31:0] q_in;
		logic [31:0] d_in;
		logic [31:0] rem_out;
		logic [31:0] q_out;
		logic [32:0] res;

		if (j == 0) begin : g_first
			assign rem_in = {1'b0, num};
			assign q_in   = '0;
			assign d_in   = den;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign q_in   = q_s[j-1];
			assign d_in   = den_s[j-1];
		end

		// four quotient bits, the very first one without a shift
		always_comb begin
			rem_out = rem_in;
			q_out   = q_in;
			res     = '0;
			for (int i = 0; i < STEPS; i++) begin
				res     = div_step(rem_out, d_in, (j != 0) || (i != 0));
				q_out   = {q_out[30:0], res[32]};
				rem_out = res[31:0];
			end
		end

		if (j < DIV_STAGES - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv[j]) begin
					rem_s[j] <= rem_out;
					den_s[j] <= d_in;
					q_s[j]   <= q_out;
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (adv[j])
					q_s[j] <= q_out;
			end
		end
	end

	assign quo = q_s[DIV_STAGES-1];

endmodule

/* hdl/dwm_tanh.sv */
module dwm_tanh import dwm_pkg::*; (
	input  logic                  clk,
	input  logic [20:0]           adv,
	input  drv_t                  a,
	input  logic [REG_W-1:0]      vol,
	output logic signed [BR_W-1:0] b
);

	logic [DRV_W-1:0]   mag;
	logic               neg_t [1:20];
	logic               sat_t [1:20];
	logic [33:0]        m_t [1:2];
	logic [58:0]        k_prod;
	logic [4:0]         k_t [2:11];
	logic [35:0]        r_full;
	logic signed [31:0] r_t [3:10];
	logic signed [31:0] acc_in [4:11];
	logic signed [31:0] acc_t [4:11];
	logic [30:0]        acc_pos;
	logic [30:0]        e_sh;
	logic [30:0]        e_c;
	logic [30:0]        num_t12;
	logic [31:0]        den_t12;
	logic [31:0]        quo;
	logic [31:0]        t_mag;
	logic signed [32:0] t_signed;
	logic signed [49:0] b_prod;

	// magnitude and saturation beyond 8
	assign mag = a[DRV_W-1] ? (DRV_W'(0) - a) : a;

	// exponent count from 1/ln2
	assign k_prod = 59'(m_t[2 - 1]) * 59'(INV_LN2_Q24);
	assign r_full = {2'b0, m_t[2]} - 36'(k_t[2]) * 36'(LN2_Q30);

	// exp horner operand feed
	always_comb begin
		acc_in[4] = EXP_COEF[8];
		for (int j = 5; j <= 11; j++)
			acc_in[j] = acc_t[j-1];
	end

	// exp(-2|a|) = 2^-k * exp(-r), clamped to [0, 1]
	assign acc_pos = acc_t[11][31] ? 31'd0 : acc_t[11][30:0];
	assign e_sh    = acc_pos >> k_t[11];
	assign e_c     = (e_sh > ONE30) ? ONE30 : e_sh;

	// (1 - e) / (1 + e)
	dwm_div u_div (
		.clk (clk),
		.adv (adv[19:12]),
		.num (num_t12),
		.den (den_t12),
		.quo (quo)
	);

	// sign restore and level
	assign t_mag    = sat_t[20] ? 32'h8000_0000 : quo;
	assign t_signed = neg_t[20] ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
	assign b_prod   = 50'(t_signed) * 50'($signed({1'b0, vol}));

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			neg_t[1] <= a[DRV_W-1];
			sat_t[1] <= |mag[DRV_W-1:34];
			m_t[1]   <= mag[33:0];
		end
		if (adv[1]) begin
			m_t[2] <= m_t[1];
			k_t[2] <= k_prod[58:54];
		end
		if (adv[2])
			r_t[3] <= $signed(r_full[31:0]);
		for (int j = 4; j <= 11; j++) begin
			if (adv[j-1]) begin
				acc_t[j] <= EXP_COEF[11-j] - 32'(mul30(acc_in[j], r_t[j-1]));
				if (j <= 10)
					r_t[j] <= r_t[j-1];
			end
		end
		for (int j = 3; j <= 11; j++) begin
			if (adv[j-1])
				k_t[j] <= k_t[j-1];
		end
		for (int j = 2; j <= 20; j++) begin
			if (adv[j-1]) begin
				neg_t[j] <= neg_t[j-1];
				sat_t[j] <= sat_t[j-1];
			end
		end
		if (adv[11]) begin
			num_t12 <= ONE30 - e_c;
			den_t12 <= {1'b0, ONE30} + {1'b0, e_c};
		end
		if (adv[20])
			b <= b_prod[47:16];
	end

endmodule

/* hdl/dual_waveshaper_distortion_mix.sv */
// throughput: one sample per cycle while the output is not stalled, through a 34-stage
// pipeline; the tanh division takes eight of those stages at four quotient bits each
// a stalled output holds only the stages behind it that are full; empty stages still fill
// arst_n clears every stage valid bit and loads the register defaults; data has no reset
module dual_waveshaper_distortion_mix import dwm_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_in_valid,
	output logic                           sample_in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           sample_out_valid,
	input  logic                           sample_out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ADDR_W-1:0]              paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int NST = 34;
	localparam int XSH = 32 - SAMPLE_WIDTH;
	localparam int SH  = 48 - SAMPLE_WIDTH;

	localparam logic [2:0] REG_GAIN_ONE   = 3'd0;
	localparam logic [2:0] REG_TONE_ONE   = 3'd1;
	localparam logic [2:0] REG_VOL_ONE    = 3'd2;
	localparam logic [2:0] REG_GAIN_TWO   = 3'd3;
	localparam logic [2:0] REG_VOL_TWO    = 3'd4;
	localparam logic [2:0] REG_MIX_AMOUNT = 3'd5;

	localparam int GAIN_ONE_RST = 13107;
	localparam int TONE_ONE_RST = 32768;
	localparam int VOL_ONE_RST  = 32768;
	localparam int GAIN_TWO_RST = 39322;
	localparam int VOL_TWO_RST  = 32768;
	localparam int MIX_RST      = 32768;

	localparam logic signed [49:0] RND    = 50'sd1 <<< (SH - 1);
	localparam logic signed [49:0] SAT_HI = (50'sd1 <<< (SAMPLE_WIDTH - 1)) - 50'sd1;
	localparam logic signed [49:0] SAT_LO = -(50'sd1 <<< (SAMPLE_WIDTH - 1));

	logic [REG_W-1:0] gain_one_q;
	logic [REG_W-1:0] tone_one_q;
	logic [REG_W-1:0] vol_one_q;
	logic [REG_W-1:0] gain_two_q;
	logic [REG_W-1:0] vol_two_q;
	logic [REG_W-1:0] mix_amount_q;
	logic [G1X_W-1:0] g1x_q;
	logic [G2X_W-1:0] g2x_q;
	logic [2:0]       reg_idx;
	logic             reg_wr;

	logic [NST:1]     vld_s;
	logic [NST:1]     adv;

	q31_t             x31_c;
	logic [31:0]      x_mag;
	logic [MT_W-1:0]  mt_c;
	logic signed [55:0] d_prod;
	q31_t             x31_s [1:10];
	drv_t             d_s [1:11];
	logic [MT_W-1:0]  mt_s1;
	logic             negx_s1;
	term_t            term_s10;
	drv_t             u_s11;
	logic signed [BR_W-1:0] b1_s32;
	logic signed [BR_W-1:0] b2_s32;
	logic [16:0]      w_one;
	logic signed [49:0] p1_c;
	logic signed [49:0] p2_c;
	logic signed [49:0] p1_s33;
	logic signed [49:0] p2_s33;
	logic signed [49:0] sum_rnd;
	logic signed [49:0] res_sh;
	logic signed [SAMPLE_WIDTH-1:0] res_s34;

	// configuration registers
	assign reg_idx = paddr[ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_one_q   <= REG_W'(GAIN_ONE_RST);
			tone_one_q   <= REG_W'(TONE_ONE_RST);
			vol_one_q    <= REG_W'(VOL_ONE_RST);
			gain_two_q   <= REG_W'(GAIN_TWO_RST);
			vol_two_q    <= REG_W'(VOL_TWO_RST);
			mix_amount_q <= REG_W'(MIX_RST);
			g1x_q        <= G1X_W'(GAIN_ONE_RST * 10);
			g2x_q        <= G2X_W'(GAIN_TWO_RST * 250);
		end else if (reg_wr) begin
			case (reg_idx)
				REG_GAIN_ONE: begin
					gain_one_q <= pwdata[REG_W-1:0];
					g1x_q      <= G1X_W'(pwdata[REG_W-1:0]) * G1X_W'(10);
				end
				REG_TONE_ONE:   tone_one_q <= pwdata[REG_W-1:0];
				REG_VOL_ONE:    vol_one_q <= pwdata[REG_W-1:0];
				REG_GAIN_TWO: begin
					gain_two_q <= pwdata[REG_W-1:0];
					g2x_q      <= G2X_W'(pwdata[REG_W-1:0]) * G2X_W'(250);
				end
				REG_VOL_TWO:    vol_two_q <= pwdata[REG_W-1:0];
				REG_MIX_AMOUNT: mix_amount_q <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAIN_ONE:   prdata = 32'(gain_one_q);
			REG_TONE_ONE:   prdata = 32'(tone_one_q);
			REG_VOL_ONE:    prdata = 32'(vol_one_q);
			REG_GAIN_TWO:   prdata = 32'(gain_two_q);
			REG_VOL_TWO:    prdata = 32'(vol_two_q);
			REG_MIX_AMOUNT: prdata = 32'(mix_amount_q);
			default:        prdata = '0;
		endcase
	end

	// stage advance: a stage loads when the output is not stalled or some stage at or after it is empty
	always_comb begin
		for (int k = 1; k <= NST; k++)
			adv[k] = !sample_out_stall || (((~vld_s) >> (k - 1)) != '0);
	end

	assign sample_in_stall  = !adv[1];
	assign sample_out_valid = vld_s[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1])
				vld_s[1] <= sample_in_valid;
			for (int k = 2; k <= NST; k++) begin
				if (adv[k])
					vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// stage 1: Q31 sample, |x| * tone, tanh drive of branch two
	assign x31_c  = X_W'(sample_in) <<< XSH;
	assign x_mag  = x31_c[X_W-1] ? (32'd0 - x31_c) : x31_c;
	assign mt_c   = MT_W'(x_mag) * MT_W'(tone_one_q);
	assign d_prod = 56'(x31_c) * 56'($signed({1'b0, g2x_q}));

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			x31_s[1] <= x31_c;
			mt_s1    <= mt_c;
			negx_s1  <= x31_c[X_W-1];
			d_s[1]   <= d_prod[55:16];
		end
		for (int k = 2; k <= 10; k++) begin
			if (adv[k])
				x31_s[k] <= x31_s[k-1];
		end
		for (int k = 2; k <= 11; k++) begin
			if (adv[k])
				d_s[k] <= d_s[k-1];
		end
	end

	// stages 2 to 10: sine foldover term
	dwm_sine u_sine (
		.clk  (clk),
		.adv  (adv[10:2]),
		.mt   (mt_s1),
		.neg  (negx_s1),
		.g1x  (g1x_q),
		.term (term_s10)
	);

	// stage 11: drive of branch one
	always_ff @(posedge clk) begin
		if (adv[11])
			u_s11 <= DRV_W'(x31_s[10]) + DRV_W'(term_s10);
	end

	// stages 12 to 32: both tanh branches side by side
	dwm_tanh u_tanh_one (
		.clk (clk),
		.adv (adv[32:12]),
		.a   (u_s11),
		.vol (vol_one_q),
		.b   (b1_s32)
	);

	dwm_tanh u_tanh_two (
		.clk (clk),
		.adv (adv[32:12]),
		.a   (d_s[11]),
		.vol (vol_two_q),
		.b   (b2_s32)
	);

	// stage 33: crossfade weights
	assign w_one = 17'h1_0000 - 17'(mix_amount_q);
	assign p1_c  = 50'(b1_s32) * 50'($signed({1'b0, w_one}));
	assign p2_c  = 50'(b2_s32) * 50'($signed({2'b0, mix_amount_q}));

	// stage 34: sum, round half up, saturate
	assign sum_rnd = p1_s33 + p2_s33 + RND;
	assign res_sh  = sum_rnd >>> SH;

	always_ff @(posedge clk) begin
		if (adv[33]) begin
			p1_s33 <= p1_c;
			p2_s33 <= p2_c;
		end
		if (adv[34]) begin
			if (res_sh > SAT_HI)
				res_s34 <= SAT_HI[SAMPLE_WIDTH-1:0];
			else if (res_sh < SAT_LO)
				res_s34 <= SAT_LO[SAMPLE_WIDTH-1:0];
			else
				res_s34 <= res_sh[SAMPLE_WIDTH-1:0];
		end
	end

	assign sample_out = res_s34;

`ifndef NO_ASSERTIONS
	// input stalls only when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_in_stall |-> (&vld_s))
		else $error("input stalled with an empty stage");

	// an input transfer lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_in_valid && !sample_in_stall) |=> vld_s[1])
		else $error("accepted sample missing from first stage");

	// an empty output register takes the next finished item
	a_out_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NST-1] && !sample_out_valid) |=> sample_out_valid)
		else $error("finished item not moved to output");
`endif

endmodule

/* dv/dual_waveshaper_distortion_mix_test.sv */
`timescale 1ns / 1ps

module dual_waveshaper_distortion_mix_test;
	import dwm_pkg::*;

	localparam int SW = 16;

	// register indexes
	localparam int REG_GAIN_ONE   = 0;
	localparam int REG_TONE_ONE   = 1;
	localparam int REG_VOL_ONE    = 2;
	localparam int REG_GAIN_TWO   = 3;
	localparam int REG_VOL_TWO    = 4;
	localparam int REG_MIX_AMOUNT = 5;
	localparam int REG_COUNT      = 6;

	localparam longint UNIT30 = 64'sd1 <<< 30;
	localparam longint SINE_POLY [5] = '{64'sd1686629713, -64'sd693598668, 64'sd85569305,
		-64'sd5026995, 64'sd172272};
	localparam longint EXP_POLY [9] = '{64'sd1073741824, 64'sd1073741824, 64'sd536870912,
		64'sd178956971, 64'sd44739243, 64'sd8947849, 64'sd1491308, 64'sd213044, 64'sd26631};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_in_valid = 1'b0;
	logic sample_in_stall;
	logic signed [SW-1:0] sample_in = '0;
	logic sample_out_valid;
	logic sample_out_stall = 1'b0;
	logic signed [SW-1:0] sample_out;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	dual_waveshaper_distortion_mix #(.SAMPLE_WIDTH(SW)) i_dut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	longint shaper_regs [REG_COUNT];
	logic signed [SW-1:0] pending_samples [$];
	logic signed [SW-1:0] expected_samples [$];
	int fail_count = 0;
	int out_count = 0;
	int in_count = 0;
	bit in_taken = 1'b0;
	bit hold_send = 1'b0;
	bit no_gaps = 1'b0;
	int send_gap = 0;
	int out_hold_cycles = 0;
	int out_gap = 0;

	// sine of 300*t1*x in Q30
	function automatic longint sine_q30(longint x31);
		bit neg;
		longint unsigned mag, prod;
		logic [31:0] phase;
		longint h, z2, acc, s;
		neg = x31 < 0;
		mag = neg ? -x31 : x31;
		prod = ((mag * longint'(shaper_regs[REG_TONE_ONE])) >> 8) * 64'd3129114;
		phase = prod[54:23];
		if (phase[31])
			neg = !neg;
		h = longint'({33'b0, phase[30:0]});
		if (h > UNIT30)
			h = 2 * UNIT30 - h;
		z2 = (h * h) >>> 30;
		acc = SINE_POLY[4];
		for (int i = 3; i >= 0; i--)
			acc = ((acc * z2) >>> 30) + SINE_POLY[i];
		s = (acc * h) >>> 30;
		if (s < 0) s = 0;
		if (s > UNIT30) s = UNIT30;
		return neg ? -s : s;
	endfunction

	// tanh of a Q31 value, Q31 result
	function automatic longint tanh_q31(longint a);
		bit neg;
		longint unsigned mag;
		longint k, r, acc, e, t;
		neg = a < 0;
		mag = neg ? -a : a;
		if (mag >= (64'd8 << 31)) begin
			t = 64'sd1 <<< 31;
		end else begin
			k = longint'((mag * 64'd24204406) >> 54);
			r = longint'(mag) - k * 64'sd744261118;
			acc = EXP_POLY[8];
			for (int i = 7; i >= 0; i--)
				acc = EXP_POLY[i] - ((acc * r) >>> 30);
			if (acc < 0) acc = 0;
			e = acc >>> k;
			if (e > UNIT30) e = UNIT30;
			t = longint'((unsigned'(UNIT30 - e) << 31) / unsigned'(UNIT30 + e));
		end
		return neg ? -t : t;
	endfunction

	// mixed output of both shaper branches
	function automatic logic signed [SW-1:0] shaped_sample(logic signed [SW-1:0] s);
		longint x31, u, d, b1, b2, mixed, res;
		x31 = longint'(s) <<< (32 - SW);
		u = x31 + ((sine_q30(x31) * shaper_regs[REG_GAIN_ONE] * 10) >>> 15);
		b1 = (tanh_q31(u) * shaper_regs[REG_VOL_ONE]) >>> 16;
		d = (x31 * shaper_regs[REG_GAIN_TWO] * 250) >>> 16;
		b2 = (tanh_q31(d) * shaper_regs[REG_VOL_TWO]) >>> 16;
		mixed = b1 * (65536 - shaper_regs[REG_MIX_AMOUNT]) + b2 * shaper_regs[REG_MIX_AMOUNT];
		res = (mixed + (64'sd1 <<< (47 - SW))) >>> (48 - SW);
		if (res > 32767) res = 32767;
		if (res < -32768) res = -32768;
		return res[SW-1:0];
	endfunction

	task automatic report(string what, logic signed [SW-1:0] got, logic signed [SW-1:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// sample sender, fed from the pending queue
	always @(negedge clk) begin
		if (!sample_in_valid || in_taken) begin
			if (send_gap > 0) begin
				sample_in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (!hold_send && pending_samples.size() > 0) begin
				sample_in_valid <= 1'b1;
				sample_in <= pending_samples.pop_front();
				send_gap <= random_gap();
			end else begin
				sample_in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with long hold-offs on request
	always @(negedge clk) begin
		if (out_hold_cycles > 0) begin
			sample_out_stall <= 1'b1;
			out_hold_cycles <= out_hold_cycles - 1;
		end else if (out_gap > 0) begin
			sample_out_stall <= 1'b1;
			out_gap <= out_gap - 1;
		end else begin
			sample_out_stall <= 1'b0;
			if ($urandom_range(0, 3) == 0)
				out_gap <= random_gap();
		end
	end

	// input transfers make predictions, output transfers are checked
	always @(posedge clk) begin
		in_taken = sample_in_valid && !sample_in_stall;
		if (arst_n && in_taken) begin
			expected_samples.insert(expected_samples.size(), shaped_sample(sample_in));
			in_count++;
		end
		if (arst_n && sample_out_valid && !sample_out_stall) begin
			out_count++;
			if (expected_samples.size() == 0) begin
				report("unexpected transfer", sample_out, '0);
			end else begin
				if (sample_out !== expected_samples[0])
					report("sample_out", sample_out, expected_samples[0]);
				void'(expected_samples.pop_front());
			end
		end
	end

	task automatic write_reg(int idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(4 * idx);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < REG_COUNT)
			shaper_regs[idx] = longint'(value[15:0]);
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || sample_in_valid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [15:0] random_reg();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'h0000;
		if (r == 1) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic logic signed [SW-1:0] random_sample();
		int r;
		int v;
		r = $urandom_range(0, 9);
		v = $urandom_range(0, 65535) - 32768;
		if (r < 2) v = $urandom_range(0, 511) - 256;
		else if (r == 2) v = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 8)
			: -32768 + $urandom_range(0, 8);
		return SW'(v);
	endfunction

	logic [15:0] setting [REG_COUNT];

	initial begin
		shaper_regs = '{13107, 32768, 32768, 39322, 32768, 32768};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed samples at reset settings
		foreach (setting[i]) setting[i] = '0;
		pending_samples = '{-16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, -16'sh0001,
			16'sh4000, -16'sh4000, 16'sh0100, -16'sh0100, 16'sh2000, -16'sh2000,
			16'sh7FFE, -16'sh7FFF, 16'sh0010, 16'sh5555, -16'sh5556};
		drain();

		for (int phase = 0; phase < 11; phase++) begin
			foreach (setting[i]) setting[i] = random_reg();
			case (phase)
				0: foreach (setting[i]) setting[i] = 16'h0000;
				1: foreach (setting[i]) setting[i] = 16'hFFFF;
				2: setting[REG_MIX_AMOUNT] = 16'h0000;
				3: setting[REG_MIX_AMOUNT] = 16'hFFFF;
				4: begin
					setting[REG_GAIN_ONE] = 16'hFFFF;
					setting[REG_TONE_ONE] = 16'hFFFF;
					setting[REG_VOL_ONE] = 16'hFFFF;
					setting[REG_MIX_AMOUNT] = 16'h0000;
				end
				default: ;
			endcase
			for (int i = 0; i < REG_COUNT; i++)
				write_reg(i, {16'($urandom), setting[i]});
			// indexes past the register file are ignored
			write_reg(REG_COUNT + (phase % 2), $urandom);

			no_gaps = (phase == 5 || phase == 8);
			if (phase == 5)
				out_hold_cycles = 300;
			for (int n = 0; n < 60; n++)
				pending_samples.insert(pending_samples.size(), random_sample());
			if (phase == 7) begin
				while (pending_samples.size() > 30) @(posedge clk);
				hold_send = 1'b1;
				while (sample_in_valid || expected_samples.size() > 0) @(posedge clk);
				hold_send = 1'b0;
			end
			drain();
		end

		$display("covered %0d samples in, %0d checked out, over 12 register settings",
			in_count, out_count);
		$display("settings included all-zero, all-full, single-branch mixes and random levels");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// timeout
	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
